### rtl/spq_pkg.sv
// Package for the sorted priority queue.
// Holds field widths, action and status codes and the controller-to-datapath command type.
// No dependencies.
package spq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int KEY_W     = 32;
    localparam int ACT_W     = 2;
    localparam int IDX_W     = 3;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 4;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 72;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

### rtl/spq_datapath.sv
// Datapath of the sorted priority queue: the row of key cells, the count and result registers.
// Depends on spq_pkg; driven by commands from spq_ctrl.
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spq_pkg::t_dp_cmd                     i_cmd,
    input  logic [spq_pkg::ACT_W-1:0]            i_action,
    input  logic signed [spq_pkg::KEY_W-1:0]     i_key,
    input  logic [spq_pkg::IDX_W-1:0]            i_index,
    output logic [spq_pkg::ST_W-1:0]             o_status,
    output logic [spq_pkg::CNT_OUT_W-1:0]        o_count,
    output logic signed [spq_pkg::KEY_W-1:0]     o_head_key,
    output logic signed [spq_pkg::KEY_W-1:0]     o_read_key
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = (CW > spq_pkg::IDX_W) ? CW : spq_pkg::IDX_W;

    logic [spq_pkg::ACT_W-1:0]             r_action;
    logic signed [spq_pkg::KEY_W-1:0]      r_key;
    logic [spq_pkg::IDX_W-1:0]             r_index;
    logic signed [spq_pkg::KEY_W-1:0]      r_entries [DEPTH];
    logic signed [spq_pkg::KEY_W-1:0]      n_entries [DEPTH];
    logic signed [spq_pkg::KEY_W-1:0]      e_dn      [DEPTH];
    logic signed [spq_pkg::KEY_W-1:0]      e_up      [DEPTH];
    logic [CW-1:0]                         r_count;
    logic [CW-1:0]                         n_count;
    logic [spq_pkg::ST_W-1:0]              r_status;
    logic [spq_pkg::ST_W-1:0]              n_status;
    logic signed [spq_pkg::KEY_W-1:0]      r_read_key;
    logic signed [spq_pkg::KEY_W-1:0]      n_read_key;
    logic signed [spq_pkg::KEY_W-1:0]      sel_key;
    logic [DEPTH-1:0]                      lt;
    logic [DEPTH-1:0]                      eq;
    logic [DEPTH-1:0]                      lt_prev;
    logic [DEPTH-1:0]                      ins_at;
    logic [DEPTH-1:0]                      del_hit;
    logic                                  found;
    logic                                  in_range;

    // Each cell compares the key with its own entry; the row is kept in descending order,
    // so the cells that hold a greater key form an unbroken run from the head.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && (r_key < r_entries[i]);
            eq[i] = (CW'(i) < r_count) && (r_key == r_entries[i]);
        end
        lt_prev = {lt[DEPTH-2:0], 1'b1};
        ins_at  = ~lt & lt_prev;
        del_hit = eq & lt_prev;
        found   = |del_hit;
        e_dn[0]       = r_entries[0];
        e_up[DEPTH-1] = r_entries[DEPTH-1];
        for (int i = 0; i < DEPTH - 1; i++) begin
            e_dn[i+1] = r_entries[i];
            e_up[i]   = r_entries[i+1];
        end
        in_range = RW'(r_index) < RW'(r_count);
        sel_key  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (RW'(r_index) == RW'(i)) begin
                sel_key = r_entries[i];
            end
        end
    end

    always_comb begin
        n_entries  = r_entries;
        n_count    = r_count;
        n_status   = spq_pkg::ST_OK;
        n_read_key = '0;
        unique case (r_action)
            spq_pkg::ACT_INSERT: begin
                if (r_count == CW'(DEPTH)) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (lt[i]) begin
                            n_entries[i] = r_entries[i];
                        end else if (ins_at[i]) begin
                            n_entries[i] = r_key;
                        end else begin
                            n_entries[i] = e_dn[i];
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            spq_pkg::ACT_DELETE: begin
                if (r_count == '0) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else if (!found) begin
                    n_status = spq_pkg::ST_NOTFOUND;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        n_entries[i] = lt[i] ? r_entries[i] : e_up[i];
                    end
                    n_count = r_count - CW'(1);
                end
            end
            spq_pkg::ACT_READ: begin
                if (in_range) begin
                    n_read_key = sel_key;
                end else begin
                    n_status = spq_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_index  <= i_index;
        end
        if (i_cmd.exec) begin
            r_entries  <= n_entries;
            r_status   <= n_status;
            r_read_key <= n_read_key;
        end
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status   = r_status;
    assign o_count    = spq_pkg::CNT_OUT_W'(r_count);
    assign o_head_key = (r_count != '0) ? r_entries[0] : '0;
    assign o_read_key = r_read_key;

endmodule

### rtl/spq_ctrl.sv
// Controller of the sorted priority queue: sequences accept, execute and result delivery.
// Depends on spq_pkg; commands spq_datapath.
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output spq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   ready;
    logic   load;

    assign ready      = i_rst_n &&
                        ((r_state == S_IDLE) || ((r_state == S_RESP) && i_m_tready));
    assign load       = ready && i_s_tvalid;
    assign o_s_tready = ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd.load = load;
    assign o_cmd.exec = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (load) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state    <= S_RESP;
                    r_m_tvalid <= 1'b1;
                end
                S_RESP: begin
                    if (i_m_tready) begin
                        r_m_tvalid <= 1'b0;
                        r_state    <= load ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_m_tvalid <= 1'b0;
                end
            endcase
        end
    end

endmodule

### rtl/sorted_priority_queue.sv
// Sorted priority queue of signed 32-bit keys, top level with stream ports.
// Instantiates spq_ctrl and spq_datapath; depends on spq_pkg.
// Each transaction is one insert, delete or read and returns one result transaction. The
// operands are captured at the accepting edge, the row of compare-and-shift cells updates
// in the execute state that follows, and the result is then offered until it is taken.
// A new transaction is taken only in the idle state or in the cycle that the result is
// taken, so a new item is not taken before the last result is taken, and a result that
// waits stalls the input until it is taken. The queue keeps up to DEPTH keys, highest
// first; an insert goes ahead of equal keys and a delete removes the first equal key.
// The count field reports the count in four bits.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // action[1:0], key[33:2], index[36:34], zero fill [39:37]
    input  logic [spq_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // status[2:0], count[6:3], head_key[38:7], read_key[70:39], zero fill [71]
    output logic [spq_pkg::OUT_W-1:0]  o_m_tdata
);

    spq_pkg::t_dp_cmd                    cmd;
    logic [spq_pkg::ST_W-1:0]            status;
    logic [spq_pkg::CNT_OUT_W-1:0]       count;
    logic signed [spq_pkg::KEY_W-1:0]    head_key;
    logic signed [spq_pkg::KEY_W-1:0]    read_key;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_action   (i_s_tdata[1:0]),
        .i_key      (i_s_tdata[33:2]),
        .i_index    (i_s_tdata[36:34]),
        .o_status   (status),
        .o_count    (count),
        .o_head_key (head_key),
        .o_read_key (read_key)
    );

    assign o_m_tdata = {1'b0, read_key, head_key, count, status};

`ifndef ASSERT_OFF
    a_no_accept_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("input taken while a result is still held");

    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("result shown in the cycle after acceptance");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (DEPTH < 16) && (o_m_tdata[6:3] == '0)) |-> (o_m_tdata[38:7] == '0))
        else $error("head key not zero on an empty queue");
`endif

endmodule

### bench/spq_checker.sv
// Checker for the sorted priority queue: watches both stream channels, predicts each result
// from its own copy of the queue contents and compares it field by field.
// Depends on spq_pkg.
module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // action[1:0], key[33:2], index[36:34], zero fill [39:37]
    input  logic [spq_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // status[2:0], count[6:3], head_key[38:7], read_key[70:39], zero fill [71]
    input  logic [spq_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [spq_pkg::KEY_W-1:0]     read_key;
        logic [spq_pkg::KEY_W-1:0]     head_key;
        logic [spq_pkg::CNT_OUT_W-1:0] count;
        logic [spq_pkg::ST_W-1:0]      status;
    } t_outcome;

    localparam int A_LO = 0;
    localparam int K_LO = spq_pkg::ACT_W;
    localparam int I_LO = spq_pkg::ACT_W + spq_pkg::KEY_W;

    logic [spq_pkg::KEY_W-1:0] sorted_keys [DEPTH];
    int                        key_count;
    t_outcome                  outcome_q [$];
    int                        mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        key_count    = 0;
    end

    function automatic t_outcome apply_op(input logic [spq_pkg::ACT_W-1:0] act,
                                          input logic [spq_pkg::KEY_W-1:0] key,
                                          input logic [spq_pkg::IDX_W-1:0] idx);
        t_outcome res;
        int       pos;
        int       j;
        res        = '0;
        res.status = spq_pkg::ST_OK;
        pos        = 0;
        case (act)
            spq_pkg::ACT_INSERT: begin
                if (key_count >= DEPTH) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    while (pos < key_count && $signed(key) < $signed(sorted_keys[pos]))
                        pos++;
                    for (j = key_count; j > pos; j--)
                        sorted_keys[j] = sorted_keys[j-1];
                    sorted_keys[pos] = key;
                    key_count++;
                end
            end
            spq_pkg::ACT_DELETE: begin
                if (key_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    while (pos < key_count && sorted_keys[pos] != key)
                        pos++;
                    if (pos >= key_count) begin
                        res.status = spq_pkg::ST_NOTFOUND;
                    end else begin
                        for (j = pos; j + 1 < key_count; j++)
                            sorted_keys[j] = sorted_keys[j+1];
                        key_count--;
                    end
                end
            end
            spq_pkg::ACT_READ: begin
                if (int'(idx) < key_count)
                    res.read_key = sorted_keys[idx];
                else
                    res.status = spq_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
        res.count    = spq_pkg::CNT_OUT_W'(key_count);
        res.head_key = (key_count > 0) ? sorted_keys[0] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            key_count = 0;
            outcome_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(apply_op(i_s_tdata[K_LO-1:A_LO],
                                             i_s_tdata[I_LO-1:K_LO],
                                             i_s_tdata[I_LO+spq_pkg::IDX_W-1:I_LO]));
            if (i_m_tvalid && i_m_tready) begin
                got = t_outcome'(i_m_tdata[$bits(t_outcome)-1:0]);
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no operation outstanding");
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                    if (got.head_key !== want.head_key) begin
                        $error("head_key: expected %0d, got %0d",
                               $signed(want.head_key), $signed(got.head_key));
                        mismatches++;
                    end
                    if (got.read_key !== want.read_key) begin
                        $error("read_key: expected %0d, got %0d",
                               $signed(want.read_key), $signed(got.read_key));
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= outcome_q.size();
    end

endmodule

### bench/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
// Instantiates sorted_priority_queue and spq_checker; depends on spq_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [spq_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 1130;
    localparam int QUIET_ITEMS  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [spq_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [spq_pkg::OUT_W-1:0] m_tdata;
    int                        fail_count;
    int                        pending;
    bit                        quiet_end = 1'b0;

    sorted_priority_queue dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    spq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    task automatic send_op(input logic [spq_pkg::ACT_W-1:0] act,
                           input logic [spq_pkg::KEY_W-1:0] key,
                           input logic [spq_pkg::IDX_W-1:0] idx);
        s_tdata  <= {{(spq_pkg::IN_W-spq_pkg::ACT_W-spq_pkg::KEY_W-spq_pkg::IDX_W){1'b0}},
                     idx, key, act};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (!quiet_end && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Small keys repeat often, so that equal keys meet and deletes find their target.
    function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
        int v;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                v = int'($urandom_range(0, 7)) - 4;
                return spq_pkg::KEY_W'(v);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int unsigned taken;
        int unsigned burst_left;
        int          long_holds;
        taken      = 0;
        burst_left = 0;
        long_holds = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (burst_left != 0) begin
                burst_left--;
            end else if (long_holds < 2 && taken >= (long_holds == 0 ? 150 : 700)) begin
                m_tready   <= 1'b0;
                burst_left = 400;
                long_holds++;
            end else if (!quiet_end && $urandom_range(0, 2) == 0) begin
                m_tready   <= 1'b0;
                burst_left = $urandom_range(1, 16) - 1;
            end else begin
                m_tready   <= 1'b1;
                burst_left = $urandom_range(1, 24) - 1;
            end
        end
    end

    initial begin : watchdog
        int unsigned still;
        still = 0;
        while (still < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                still = 0;
            else
                still++;
        end
        $display("FAIL sorted_priority_queue");
        $finish;
    end

    initial begin
        int                          insert_pct;
        int                          roll;
        logic [spq_pkg::ACT_W-1:0]   act;
        insert_pct = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_op(spq_pkg::ACT_READ,   32'd0,          3'd0);
        send_op(spq_pkg::ACT_DELETE, 32'd7,          3'd0);
        send_op(ACT_NOP,             32'd0,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'h7FFF_FFFF,  3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'h8000_0000,  3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd0,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'hFFFF_FFFF,  3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd0,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd5,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd5,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd1,          3'd0);
        send_op(spq_pkg::ACT_INSERT, 32'd3,          3'd0);
        send_op(spq_pkg::ACT_READ,   32'd0,          3'd0);
        send_op(spq_pkg::ACT_READ,   32'd0,          3'd7);
        send_op(spq_pkg::ACT_DELETE, 32'd12345,      3'd0);
        send_op(spq_pkg::ACT_DELETE, 32'd0,          3'd0);
        send_op(spq_pkg::ACT_DELETE, 32'h8000_0000,  3'd0);
        send_op(spq_pkg::ACT_READ,   32'd0,          3'd6);
        send_op(spq_pkg::ACT_READ,   32'd0,          3'd5);
        send_op(ACT_NOP,             32'hFFFF_FFFF,  3'd7);
        send_op(spq_pkg::ACT_DELETE, 32'h7FFF_FFFF,  3'd0);
        send_op(spq_pkg::ACT_READ,   32'hFFFF_FFFF,  3'd3);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_end = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = ACT_NOP;
            else if (roll < 25)
                act = spq_pkg::ACT_READ;
            else if ($urandom_range(0, 99) < insert_pct)
                act = spq_pkg::ACT_INSERT;
            else
                act = spq_pkg::ACT_DELETE;
            send_op(act, pick_key(), spq_pkg::IDX_W'($urandom_range(0, 7)));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
bench/spq_checker.sv
bench/tb_top.sv
